[hw/rtl/mvtp_pkg.sv]
// Shared types, character codes and helper functions for the vertex token parser.
// No dependencies; every file but mvtp_ifs imports this package.
package mvtp_pkg;

	// Parser phases.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SIGN   = 3'd1;
	localparam logic [2:0] PH_DIGITS = 3'd2;
	localparam logic [2:0] PH_COMMA  = 3'd3;
	localparam logic [2:0] PH_ZERO   = 3'd4;
	localparam logic [2:0] PH_HEX    = 3'd5;

	// Character codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_X     = 8'h78;

	// Reset value of the default color register.
	localparam logic [31:0] DEFAULT_COLOR_RST = 32'h0000_AAAA;

	// Depth of the result queue; must be a power of two and at least 2.
	localparam int RQ_DEPTH = 4;

	// Token state carried from one character to the next.
	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] mag;
		logic        neg;
		logic [31:0] acc;
	} tok_state_t;

	localparam tok_state_t TOK_CLEAR = '{phase: PH_IDLE, mag: '0, neg: 1'b0, acc: '0};

	// One result word.
	typedef struct packed {
		logic signed [31:0] height;
		logic [31:0]        color;
		logic               last_of_run;
	} vtx_t;

	// Up to two results caused by one character, first one in v0.
	typedef struct packed {
		logic vld0;
		logic vld1;
		vtx_t v0;
		vtx_t v1;
	} vtx_pair_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
	endfunction

	// Digits map to their low nibble; letters a-f and A-F have low nibbles 1-6.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		if (is_digit(c)) begin
			v = c[3:0];
		end else if (is_hex(c)) begin
			v = c[3:0] + 4'd9;
		end else begin
			v = 4'd0;
		end
		return v;
	endfunction

endpackage

[hw/rtl/mvtp_ifs.sv]
// Valid/ready channel interfaces for the character input and the vertex output.
// Depends on nothing.
interface mvtp_ch_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

interface mvtp_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] height;
	logic [31:0]        color;
	logic               last_of_run;

	modport source (output valid, output height, output color, output last_of_run, input ready);
	modport sink   (input valid, input height, input color, input last_of_run, output ready);
endinterface

[hw/rtl/mvtp_core.sv]
// Token state register and the per-character next-state and result logic.
// Depends on mvtp_pkg.
module mvtp_core import mvtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  ch,
	input  logic [31:0] default_color,
	output vtx_pair_t   res
);

	tok_state_t  st_q;
	tok_state_t  nxt;
	tok_state_t  idle_nxt;
	logic        idle_stray;
	logic        vld0;
	logic        vld1;
	logic        digit;
	logic [31:0] dval;
	logic [31:0] mag10;
	logic [31:0] acc16;
	logic [31:0] h_cur;

	assign digit = is_digit(ch);
	assign dval  = {28'd0, ch[3:0]};
	assign mag10 = (st_q.mag << 3) + (st_q.mag << 1) + dval;
	assign acc16 = {st_q.acc[27:0], hex_val(ch)};
	assign h_cur = st_q.neg ? (32'd0 - st_q.mag) : st_q.mag;

	// What a character does to a cleared token: start one, or end an empty one.
	always_comb begin
		idle_nxt   = TOK_CLEAR;
		idle_stray = 1'b0;
		if (ch == CH_MINUS || ch == CH_PLUS) begin
			idle_nxt.neg   = (ch == CH_MINUS);
			idle_nxt.phase = PH_SIGN;
		end else if (digit) begin
			idle_nxt.mag   = dval;
			idle_nxt.phase = PH_DIGITS;
		end else if (ch == CH_COMMA) begin
			idle_nxt.phase = PH_COMMA;
		end else if (ch != CH_NUL && !is_space(ch)) begin
			idle_stray = 1'b1;
		end
	end

	// Phase decoder. A failed prefix emits the token and parses the character again,
	// which is where the second result comes from.
	always_comb begin
		nxt  = st_q;
		vld0 = 1'b0;
		vld1 = 1'b0;
		unique case (st_q.phase) inside
			PH_IDLE: begin
				nxt  = idle_nxt;
				vld0 = idle_stray;
			end
			PH_SIGN, PH_DIGITS: begin
				if (digit) begin
					nxt.mag   = mag10;
					nxt.phase = PH_DIGITS;
				end else if (ch == CH_COMMA) begin
					nxt.phase = PH_COMMA;
				end else begin
					vld0 = 1'b1;
					nxt  = TOK_CLEAR;
				end
			end
			PH_COMMA: begin
				if (ch == CH_0) begin
					nxt.phase = PH_ZERO;
				end else begin
					vld0 = 1'b1;
					nxt  = idle_nxt;
					vld1 = idle_stray;
				end
			end
			PH_ZERO: begin
				if (ch == CH_X) begin
					nxt.phase = PH_HEX;
					nxt.acc   = '0;
				end else begin
					// The zero starts a new token; the character continues it.
					vld0 = 1'b1;
					nxt  = TOK_CLEAR;
					if (digit) begin
						nxt.mag   = dval;
						nxt.phase = PH_DIGITS;
					end else if (ch == CH_COMMA) begin
						nxt.phase = PH_COMMA;
					end else begin
						vld1 = 1'b1;
					end
				end
			end
			PH_HEX: begin
				if (is_hex(ch)) begin
					nxt.acc = acc16;
				end else begin
					vld0 = 1'b1;
					nxt  = TOK_CLEAR;
				end
			end
			default: begin
				nxt = TOK_CLEAR;
			end
		endcase
	end

	// Results; a second result is always an empty token with the default color.
	always_comb begin
		res.vld0              = accept & vld0;
		res.vld1              = accept & vld1;
		res.v0.height         = h_cur;
		res.v0.color          = (st_q.phase == PH_HEX) ? st_q.acc : default_color;
		res.v0.last_of_run    = ~vld1;
		res.v1.height         = '0;
		res.v1.color          = default_color;
		res.v1.last_of_run    = 1'b1;
	end

	// Token state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= TOK_CLEAR;
		end else if (accept) begin
			st_q <= nxt;
		end
	end

endmodule

[hw/rtl/mvtp_rq.sv]
// Result queue: up to two vertex words in a cycle, one out a cycle while ready.
// Depends on mvtp_pkg and mvtp_vtx_if.
module mvtp_rq import mvtp_pkg::*; #(
	parameter int DEPTH = RQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  vtx_pair_t  push,
	output logic       room,
	mvtp_vtx_if.source out
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	vtx_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_push;
	logic             pop;
	vtx_t             head;

	assign n_push = CNT_W'(push.vld0) + CNT_W'(push.vld1);
	assign pop    = out.valid & out.ready;
	// Room for the worst case of two words from the next character.
	assign room   = (count_q <= CNT_W'(DEPTH - 2));

	// Head of the queue drives the output channel.
	assign head            = mem[rd_ptr_q];
	assign out.valid       = (count_q != '0);
	assign out.height      = head.height;
	assign out.color       = head.color;
	assign out.last_of_run = head.last_of_run;

	// Storage writes; the second word follows the first.
	always_ff @(posedge clk) begin
		if (push.vld0) begin
			mem[wr_ptr_q] <= push.v0;
		end
		if (push.vld1) begin
			mem[wr_ptr_q + PTR_W'(1)] <= push.v1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

endmodule

[hw/rtl/map_vertex_token_parser.sv]
// Height-map vertex token parser: one character a cycle in, vertex words out.
// A character is taken in every cycle while the result queue has room for two words.
// A vertex word enters the result queue as the character ending its token is taken;
// the queue sets the output rate of one word per cycle while out_vtx.ready is high.
// Reset clears the token state and the queue and sets default_color to 0x0000AAAA.
// Depends on mvtp_pkg, mvtp_ifs, mvtp_core and mvtp_rq.
module map_vertex_token_parser import mvtp_pkg::*; #(
	parameter int RQ_DEPTH_P = RQ_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	mvtp_ch_if.sink     in_ch,
	mvtp_vtx_if.source  out_vtx
);

	logic [31:0] default_color_q;
	logic        room;
	logic        accept;
	vtx_pair_t   res;

	assign in_ch.ready = room;
	assign accept      = in_ch.valid & room;

	// Default color register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_color_q <= DEFAULT_COLOR_RST;
		end else if (cfg_we) begin
			default_color_q <= cfg_wdata;
		end
	end

	mvtp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.ch            (in_ch.ch),
		.default_color (default_color_q),
		.res           (res)
	);

	mvtp_rq #(
		.DEPTH (RQ_DEPTH_P)
	) u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res),
		.room   (room),
		.out    (out_vtx)
	);

endmodule

[sim/map_vertex_token_parser_tb.sv]
// Self-checking testbench for map_vertex_token_parser: character words in, vertex words out.
// Depends on mvtp_pkg, the channel interfaces in mvtp_ifs and the parser RTL.
// A directed script runs first, then random token streams under several default colors.
module map_vertex_token_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mvtp_pkg::*;

	localparam int HOLD_CYCLES   = 60;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	localparam int PHASE_CHARS   = 450;
	localparam logic [31:0] DFLT = DEFAULT_COLOR_RST;

	// One row of the directed script; typed rows carry their expected vertex words.
	typedef struct packed {
		logic [7:0]  c;
		logic        typed;
		logic [1:0]  nres;
		logic [31:0] h0;
		logic [31:0] c0;
		logic [31:0] h1;
		logic [31:0] c1;
	} script_row_t;

	localparam script_row_t TOKEN_SCRIPT [28] = '{
		'{"7",    1'b1, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{" ",    1'b1, 2'd1, 32'd7,          DFLT,      32'd0, 32'd0},
		'{"-",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"2",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{",",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"0",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"x",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"F",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"f",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{8'hFF,  1'b1, 2'd1, 32'hFFFF_FFFE,  32'h0000_00FF, 32'd0, 32'd0},
		'{"+",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"+",    1'b1, 2'd1, 32'd0,          DFLT,      32'd0, 32'd0},
		'{",",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"5",    1'b1, 2'd1, 32'd0,          DFLT,      32'd0, 32'd0},
		'{",",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"0",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"x",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{CH_TAB, 1'b1, 2'd1, 32'd5,          32'd0,     32'd0, 32'd0},
		'{",",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"0",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"9",    1'b1, 2'd1, 32'd0,          DFLT,      32'd0, 32'd0},
		'{",",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"0",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"z",    1'b1, 2'd2, 32'd9,          DFLT,      32'd0, DFLT},
		'{"#",    1'b1, 2'd1, 32'd0,          DFLT,      32'd0, 32'd0},
		'{CH_NUL, 1'b1, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{"3",    1'b0, 2'd0, 32'd0,          32'd0,     32'd0, 32'd0},
		'{CH_NUL, 1'b1, 2'd1, 32'd3,          DFLT,      32'd0, 32'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	mvtp_ch_if  ch_if();
	mvtp_vtx_if vtx_if();

	// Shared between the driving processes.
	bit idle_on = 1'b1;
	bit vtx_hold = 1'b0;
	int mismatch_count = 0;

	// Parser state mirrored by the predictor.
	logic [2:0]  p_phase = PH_IDLE;
	logic [31:0] p_mag = '0;
	logic        p_neg = 1'b0;
	logic [31:0] p_acc = '0;
	logic [31:0] p_dflt = DEFAULT_COLOR_RST;

	vtx_t        run_out[$];
	vtx_t        vtx_expected[$];
	logic [7:0]  pending_chars[$];

	map_vertex_token_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (ch_if),
		.out_vtx   (vtx_if)
	);

	always #10 clk = ~clk;

	// Character classes used by the predictor.
	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_decimal(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_hex_char(input logic [7:0] c);
		return is_decimal(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= CH_LA) begin
			return 4'(c - CH_LA + 8'd10);
		end
		if (c >= CH_UA) begin
			return 4'(c - CH_UA + 8'd10);
		end
		return c[3:0];
	endfunction

	// Finishes the current token as one vertex word and clears the token.
	function automatic void emit_vertex(input logic [31:0] col);
		vtx_t v;
		v.height = p_neg ? (32'd0 - p_mag) : p_mag;
		v.color = col;
		v.last_of_run = 1'b0;
		run_out.push_back(v);
		p_phase = PH_IDLE;
		p_mag = '0;
		p_neg = 1'b0;
		p_acc = '0;
	endfunction

	// Advances the token state by one character; the vertex words it causes land in run_out.
	function automatic void parse_char(input logic [7:0] c);
		bit again;
		run_out.delete();
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			case (p_phase)
				PH_IDLE: begin
					if (c == CH_NUL || is_blank(c)) begin
						// Skipped while no token is open.
					end else if (c == CH_MINUS || c == CH_PLUS) begin
						p_neg = (c == CH_MINUS);
						p_phase = PH_SIGN;
					end else if (is_decimal(c)) begin
						p_mag = 32'(c - CH_0);
						p_phase = PH_DIGITS;
					end else if (c == CH_COMMA) begin
						p_phase = PH_COMMA;
					end else begin
						emit_vertex(p_dflt);
					end
				end
				PH_SIGN, PH_DIGITS: begin
					if (is_decimal(c)) begin
						p_mag = p_mag * 32'd10 + 32'(c - CH_0);
						p_phase = PH_DIGITS;
					end else if (c == CH_COMMA) begin
						p_phase = PH_COMMA;
					end else begin
						emit_vertex(p_dflt);
					end
				end
				PH_COMMA: begin
					// Anything but '0' closes the token and is parsed again from idle.
					if (c == CH_0) begin
						p_phase = PH_ZERO;
					end else begin
						emit_vertex(p_dflt);
						again = 1'b1;
					end
				end
				PH_ZERO: begin
					// Anything but 'x' closes the token and opens a new one holding 0.
					if (c == CH_X) begin
						p_phase = PH_HEX;
						p_acc = '0;
					end else begin
						emit_vertex(p_dflt);
						p_phase = PH_DIGITS;
						again = 1'b1;
					end
				end
				PH_HEX: begin
					if (is_hex_char(c)) begin
						p_acc = {p_acc[27:0], hex_nibble(c)};
					end else begin
						emit_vertex(p_acc);
					end
				end
				default: begin
					p_phase = PH_IDLE;
					again = 1'b1;
				end
			endcase
		end
		if (run_out.size() > 0) begin
			run_out[run_out.size() - 1].last_of_run = 1'b1;
		end
	endfunction

	function automatic void predict_char(input logic [7:0] c);
		parse_char(c);
		foreach (run_out[i]) begin
			vtx_expected.push_back(run_out[i]);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Offers one character word and returns at the falling edge after it was taken.
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			ch_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ch_if.valid <= 1'b1;
		ch_if.ch <= c;
		do @(posedge clk); while (!ch_if.ready);
		@(negedge clk);
	endtask

	task automatic stop_input();
		ch_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Waits for every expected vertex word, up to DRAIN_LIMIT, then lets the pipeline settle.
	task automatic wait_drained(input int settle);
		int n;
		n = 0;
		while (vtx_expected.size() > 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_default_color(input logic [31:0] col);
		cfg_we <= 1'b1;
		cfg_wdata <= col;
		@(posedge clk);
		p_dflt = col;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] blank_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 0) ? CH_SPACE : 8'(CH_TAB + r - 1);
	endfunction

	function automatic logic [7:0] hex_char();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) begin
			return 8'(CH_0 + $urandom_range(0, 9));
		end
		if (r == 1) begin
			return 8'(CH_LA + $urandom_range(0, 5));
		end
		return 8'(CH_UA + $urandom_range(0, 5));
	endfunction

	// Queues the characters of one random token: mostly well formed, some broken, some noise.
	function automatic void queue_token();
		int kind;
		int r;
		int nd;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			repeat ($urandom_range(0, 2)) pending_chars.push_back(blank_char());
			r = $urandom_range(0, 3);
			if (r == 0) begin
				pending_chars.push_back(CH_MINUS);
			end else if (r == 1) begin
				pending_chars.push_back(CH_PLUS);
			end
			// A few long numbers make the decimal accumulator wrap.
			nd = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
			repeat (nd) pending_chars.push_back(8'(CH_0 + $urandom_range(0, 9)));
			if ($urandom_range(0, 2) != 0) begin
				pending_chars.push_back(CH_COMMA);
				pending_chars.push_back(CH_0);
				pending_chars.push_back(CH_X);
				nd = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
				repeat (nd) pending_chars.push_back(hex_char());
			end
			r = $urandom_range(0, 19);
			if (r < 12) begin
				pending_chars.push_back(blank_char());
			end else if (r < 15) begin
				pending_chars.push_back(CH_NUL);
			end else begin
				pending_chars.push_back(8'($urandom_range(0, 255)));
			end
		end else if (kind == 7) begin
			// Broken color prefix.
			pending_chars.push_back(8'(CH_0 + $urandom_range(0, 9)));
			pending_chars.push_back(CH_COMMA);
			if ($urandom_range(0, 1) == 1) begin
				pending_chars.push_back(CH_0);
			end
			r = $urandom_range(0, 3);
			if (r == 0) begin
				pending_chars.push_back(CH_COMMA);
			end else if (r == 1) begin
				pending_chars.push_back(8'(CH_0 + $urandom_range(0, 9)));
			end else begin
				pending_chars.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			repeat ($urandom_range(1, 3)) pending_chars.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic run_random(input int budget);
		int sent;
		logic [7:0] c;
		sent = 0;
		while (sent < budget) begin
			// Now and then switch between idling and back-to-back stretches.
			if ($urandom_range(0, 29) == 0) begin
				idle_on = !idle_on;
			end
			queue_token();
			while (pending_chars.size() > 0) begin
				c = pending_chars.pop_front();
				send_char(c);
				predict_char(c);
				sent++;
			end
		end
	endtask

	// Main stimulus: reset, directed script, then random phases under several default colors.
	initial begin : stimulus
		script_row_t row;
		vtx_t v;
		logic [31:0] col;
		ch_if.valid = 1'b0;
		ch_if.ch = 8'd0;
		cfg_we = 1'b0;
		cfg_wdata = 32'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (TOKEN_SCRIPT[i]) begin
			row = TOKEN_SCRIPT[i];
			send_char(row.c);
			if (row.typed) begin
				parse_char(row.c);
				if (row.nres > 0) begin
					v.height = row.h0;
					v.color = row.c0;
					v.last_of_run = (row.nres == 2'd1);
					vtx_expected.push_back(v);
				end
				if (row.nres > 1) begin
					v.height = row.h1;
					v.color = row.c1;
					v.last_of_run = 1'b1;
					vtx_expected.push_back(v);
				end
			end else begin
				predict_char(row.c);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			stop_input();
			wait_drained(SETTLE_CYCLES);
			case (ph)
				0: col = 32'h0000_0000;
				1: col = 32'hFFFF_FFFF;
				default: col = $urandom;
			endcase
			write_default_color(col);
			// One long receiver stall while characters keep coming.
			if (ph == 1) begin
				vtx_hold = 1'b1;
			end
			run_random(PHASE_CHARS);
		end

		stop_input();
		wait_drained(TAIL_CYCLES);
		if (vtx_expected.size() > 0) begin
			report_mismatch("vertex words never seen", vtx_expected.size(), 32'd0);
		end
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Receiver: random ready gaps per word, plus one long hold on request.
	initial begin : vertex_sink
		int gap;
		vtx_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (vtx_hold) begin
				vtx_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				vtx_hold = 1'b0;
			end
			gap = idle_on ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				vtx_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			vtx_if.ready <= 1'b1;
			do @(posedge clk); while (!(vtx_if.valid && vtx_if.ready));
			@(negedge clk);
		end
	end

	// Compares each accepted vertex word with the oldest expected one.
	always @(posedge clk) begin : vertex_check
		vtx_t want;
		if (arst_n && vtx_if.valid && vtx_if.ready) begin
			if (vtx_expected.size() == 0) begin
				report_mismatch("vertex word with none expected", vtx_if.height, 32'd0);
			end else begin
				want = vtx_expected.pop_front();
				if (vtx_if.height !== want.height) begin
					report_mismatch("height", vtx_if.height, want.height);
				end
				if (vtx_if.color !== want.color) begin
					report_mismatch("color", vtx_if.color, want.color);
				end
				if (vtx_if.last_of_run !== want.last_of_run) begin
					report_mismatch("last_of_run", 32'(vtx_if.last_of_run),
						32'(want.last_of_run));
				end
			end
		end
	end

	// Hard limit on the run.
	initial begin : watchdog
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
